>>> hdl/eocs_pkg.sv
package eocs_pkg;

  localparam int NUM_REGISTERS = 8;
  localparam int REG_AW        = 3;
  localparam int WORD_W        = 32;
  localparam int PC_W          = 16;

  // item operations
  localparam logic [1:0] OPN_STORE = 2'd0;
  localparam logic [1:0] OPN_EXEC  = 2'd1;
  localparam logic [1:0] OPN_RDREG = 2'd2;
  localparam logic [1:0] OPN_RDMEM = 2'd3;

  // instruction opcodes, bits 24:22
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_NOR  = 3'd1;
  localparam logic [2:0] OP_LW   = 3'd2;
  localparam logic [2:0] OP_SW   = 3'd3;
  localparam logic [2:0] OP_BEQ  = 3'd4;
  localparam logic [2:0] OP_JALR = 3'd5;
  localparam logic [2:0] OP_HALT = 3'd6;
  localparam logic [2:0] OP_NOOP = 3'd7;

  // machine status
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]               operation;
    logic [15:0]              address;
    logic signed [WORD_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [PC_W-1:0]          program_counter;
    logic signed [WORD_W-1:0] read_data;
    logic [WORD_W-1:0]        executed_count;
  } out_item_t;

endpackage

>>> hdl/eight_op_cpu_step.sv
// Path from acceptance to a registered result: store, register read and memory read items
// finish in their own state, and execute items on a stopped machine or with nonzero bits
// 31:25 finish in decode; add, nor, sw, beq, jalr, halt and noop pass decode and execute; lw
// passes decode (fetch), execute (register read) and a load state (data read). The next item
// is taken on the edge that registers the current result; a stalled output holds the finishing state.
// Reset (synchronous, active low) clears pc, status, count, register file; memory is kept.
module eight_op_cpu_step #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  eocs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output eocs_pkg::out_item_t  out_data
);
  import eocs_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    S_IDLE, S_STORE, S_RDREG, S_RDMEM, S_DEC, S_EXE, S_LW
  } state_t;

  state_t              state_r, state_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [WORD_W-1:0]   cnt_r, cnt_nxt;
  in_item_t            it_r;
  logic [WORD_W-1:0]   ir_r;
  logic                out_valid_r;
  out_item_t           out_r;
  logic [WORD_W-1:0]   rd_val;

  logic                accept, fire, final_st, out_free, dec_stop;

  // register file
  logic [WORD_W-1:0]      rf_mem [NUM_REGISTERS];
  logic [NUM_REGISTERS-1:0] rf_vld_r;
  logic [WORD_W-1:0]      rfa_q_r, rfb_q_r;
  logic                   rf_re, rf_we;
  logic [REG_AW-1:0]      rf_wa, rfa_addr, rfb_addr;
  logic [WORD_W-1:0]      rf_wd;

  // word memory
  logic [WORD_W-1:0]   mem [MEM_WORDS];
  logic [WORD_W-1:0]   mem_raw_r, mem_fwd_data_r, mem_rdata;
  logic                mem_fwd_r;
  logic                mem_re, mem_we;
  logic [AW-1:0]       mem_ra, mem_wa;
  logic [WORD_W-1:0]   mem_wd;

  // instruction fields
  logic [2:0]          ex_op;
  logic [REG_AW-1:0]   ex_ra, ex_rb, ex_rd;
  logic [WORD_W-1:0]   off_sext, eff_addr, link, cnt_inc;
  logic [PC_W-1:0]     pc_inc;

  assign ex_op    = ir_r[24:22];
  assign ex_ra    = ir_r[21:19];
  assign ex_rb    = ir_r[18:16];
  assign ex_rd    = ir_r[2:0];
  assign off_sext = {{16{ir_r[15]}}, ir_r[15:0]};
  assign eff_addr = rfa_q_r + off_sext;
  assign pc_inc   = pc_r + 16'd1;
  assign link     = {16'd0, pc_r} + 32'd1;
  assign cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + 32'd1;

  assign dec_stop = (status_r != ST_RUN) || (mem_rdata[31:25] != 7'd0);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    final_st = 1'b0;
    unique case (state_r)
      S_IDLE:                    final_st = 1'b0;
      S_STORE, S_RDREG, S_RDMEM: final_st = 1'b1;
      S_DEC:                     final_st = dec_stop;
      S_EXE:                     final_st = (ex_op != OP_LW);
      S_LW:                      final_st = 1'b1;
      default:                   final_st = 1'b0;
    endcase
  end

  assign fire     = final_st && out_free;
  assign in_stall = !((state_r == S_IDLE) || fire);
  assign accept   = in_valid && !in_stall;

  // effects of the finishing transaction; writes only on fire
  always_comb begin
    pc_nxt     = pc_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    rd_val     = '0;
    rf_we      = 1'b0;
    rf_wa      = ex_rd;
    rf_wd      = '0;
    mem_we     = 1'b0;
    mem_wa     = it_r.address[AW-1:0];
    mem_wd     = it_r.write_data;
    unique case (state_r)
      S_STORE: mem_we = fire;
      S_RDREG: rd_val = rfa_q_r;
      S_RDMEM: rd_val = mem_rdata;
      S_DEC: begin
        if (status_r == ST_RUN && mem_rdata[31:25] != 7'd0) status_nxt = ST_BAD;
      end
      S_EXE: begin
        cnt_nxt = cnt_inc;
        pc_nxt  = pc_inc;
        case (ex_op)
          OP_ADD: begin
            rf_we = fire;
            rf_wd = rfa_q_r + rfb_q_r;
          end
          OP_NOR: begin
            rf_we = fire;
            rf_wd = ~(rfa_q_r | rfb_q_r);
          end
          OP_SW: begin
            mem_we = fire;
            mem_wa = eff_addr[AW-1:0];
            mem_wd = rfb_q_r;
          end
          OP_BEQ: begin
            if (rfa_q_r == rfb_q_r) pc_nxt = pc_r + 16'd1 + ir_r[15:0];
          end
          OP_JALR: begin
            rf_we  = fire;
            rf_wa  = ex_rb;
            rf_wd  = link;
            // link lands first, so regA == regB jumps to pc + 1
            pc_nxt = (ex_ra == ex_rb) ? pc_inc : rfa_q_r[PC_W-1:0];
          end
          OP_HALT: begin
            pc_nxt     = pc_r;
            status_nxt = ST_HALT;
          end
          default: ; // lw finishes in S_LW, noop only advances
        endcase
      end
      S_LW: begin
        rf_we   = fire;
        rf_wa   = ex_rb;
        rf_wd   = mem_rdata;
        cnt_nxt = cnt_inc;
        pc_nxt  = pc_inc;
      end
      default: ;
    endcase
  end

  // read port selection
  always_comb begin
    mem_re   = 1'b0;
    mem_ra   = pc_nxt[AW-1:0];
    rf_re    = 1'b0;
    rfa_addr = mem_rdata[21:19];
    rfb_addr = mem_rdata[18:16];
    if (accept && in_data.operation == OPN_EXEC) begin
      mem_re = 1'b1;
    end else if (accept && in_data.operation == OPN_RDMEM) begin
      mem_re = 1'b1;
      mem_ra = in_data.address[AW-1:0];
    end else if (state_r == S_EXE && ex_op == OP_LW) begin
      mem_re = 1'b1;
      mem_ra = eff_addr[AW-1:0];
    end
    if (accept && in_data.operation == OPN_RDREG) begin
      rf_re    = 1'b1;
      rfa_addr = in_data.address[REG_AW-1:0];
    end else if (state_r == S_DEC && !dec_stop) begin
      rf_re = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      unique case (in_data.operation)
        OPN_STORE: state_nxt = S_STORE;
        OPN_EXEC:  state_nxt = S_DEC;
        OPN_RDREG: state_nxt = S_RDREG;
        OPN_RDMEM: state_nxt = S_RDMEM;
        default:   state_nxt = S_IDLE;
      endcase
    end else if (fire) begin
      state_nxt = S_IDLE;
    end else if (state_r == S_DEC && !dec_stop) begin
      state_nxt = S_EXE;
    end else if (state_r == S_EXE && ex_op == OP_LW) begin
      state_nxt = S_LW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      status_r    <= ST_RUN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rf_vld_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fire || (out_valid_r && out_stall);
      if (fire) begin
        pc_r     <= pc_nxt;
        status_r <= status_nxt;
        cnt_r    <= cnt_nxt;
        out_r    <= '{status: status_nxt, program_counter: pc_nxt,
                      read_data: rd_val, executed_count: cnt_nxt};
      end
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
      if (accept) it_r <= in_data;
      if (state_r == S_DEC) ir_r <= mem_rdata;
    end
  end

  // register file: entries never written read as zero, same-edge write forwarded
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (rf_re) begin
      if (rf_we && rf_wa == rfa_addr)  rfa_q_r <= rf_wd;
      else if (!rf_vld_r[rfa_addr])    rfa_q_r <= '0;
      else                             rfa_q_r <= rf_mem[rfa_addr];
      if (rf_we && rf_wa == rfb_addr)  rfb_q_r <= rf_wd;
      else if (!rf_vld_r[rfb_addr])    rfb_q_r <= '0;
      else                             rfb_q_r <= rf_mem[rfb_addr];
    end
  end

  // word memory: a read issued on the write edge sees the new word
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      mem_raw_r      <= mem[mem_ra];
      mem_fwd_data_r <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_fwd_r <= 1'b0;
    end else if (mem_re) begin
      mem_fwd_r <= mem_we && (mem_wa == mem_ra);
    end
  end

  assign mem_rdata = mem_fwd_r ? mem_fwd_data_r : mem_raw_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_stopped_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != ST_RUN) |=> (status_r == $past(status_r)) && $stable(pc_r) && $stable(cnt_r))
    else $error("stopped machine changed pc, count or status");

  a_lw_after_exe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LW) |-> ($past(state_r) == S_EXE || $past(state_r) == S_LW))
    else $error("load data phase entered without execute phase");

  a_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> accept)
    else $error("memory read and write overlap outside a new transaction");

endmodule
